### rtl/core/brn_pkg.sv
// ----------------------------------------------------------------------------
// brn_pkg: shared types, constants and microcode for the Roman numeral block
// Holds the ASCII letter codes, the control word layout and the microcode
// ROM that the sequencer walks for each number.
// ----------------------------------------------------------------------------
package brn_pkg;

    localparam int unsigned VALUE_W = 12;
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned PC_W    = 5;

    // ASCII letters
    localparam logic [SYM_W-1:0] CH_I = 8'h49;
    localparam logic [SYM_W-1:0] CH_V = 8'h56;
    localparam logic [SYM_W-1:0] CH_X = 8'h58;
    localparam logic [SYM_W-1:0] CH_L = 8'h4C;
    localparam logic [SYM_W-1:0] CH_C = 8'h43;
    localparam logic [SYM_W-1:0] CH_D = 8'h44;
    localparam logic [SYM_W-1:0] CH_M = 8'h4D;
    localparam logic [SYM_W-1:0] CH_NONE = 8'h00;

    localparam logic [PC_W-1:0] PC_END = 5'd20;

    // OP_DROP: subtract k silently if remainder >= k, then advance
    // OP_REP : while remainder >= k emit letter and subtract k, else advance
    // OP_PRE : if remainder >= k emit letter (no subtract) and advance,
    //          else jump to target
    // OP_SUB : emit letter, subtract k, advance
    // OP_END : finish
    typedef enum logic [2:0] {
        OP_DROP,
        OP_REP,
        OP_PRE,
        OP_SUB,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] kval;
        logic [SYM_W-1:0]   sym;
        logic [PC_W-1:0]    tgt;
    } t_uword;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_emit;

    function automatic t_uword mk_uword(input t_op op, input logic [VALUE_W-1:0] kval,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [PC_W-1:0] tgt);
        t_uword w;
        w.op   = op;
        w.kval = kval;
        w.sym  = sym;
        w.tgt  = tgt;
        return w;
    endfunction

    // Greedy subtractive program; a thousands digit of four is dropped unprinted.
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:    w = mk_uword(OP_DROP, 12'd4000, CH_NONE, 5'd0);
            5'd1:    w = mk_uword(OP_REP,  12'd1000, CH_M,    5'd0);
            5'd2:    w = mk_uword(OP_PRE,  12'd900,  CH_C,    5'd4);
            5'd3:    w = mk_uword(OP_SUB,  12'd900,  CH_M,    5'd0);
            5'd4:    w = mk_uword(OP_REP,  12'd500,  CH_D,    5'd0);
            5'd5:    w = mk_uword(OP_PRE,  12'd400,  CH_C,    5'd7);
            5'd6:    w = mk_uword(OP_SUB,  12'd400,  CH_D,    5'd0);
            5'd7:    w = mk_uword(OP_REP,  12'd100,  CH_C,    5'd0);
            5'd8:    w = mk_uword(OP_PRE,  12'd90,   CH_X,    5'd10);
            5'd9:    w = mk_uword(OP_SUB,  12'd90,   CH_C,    5'd0);
            5'd10:   w = mk_uword(OP_REP,  12'd50,   CH_L,    5'd0);
            5'd11:   w = mk_uword(OP_PRE,  12'd40,   CH_X,    5'd13);
            5'd12:   w = mk_uword(OP_SUB,  12'd40,   CH_L,    5'd0);
            5'd13:   w = mk_uword(OP_REP,  12'd10,   CH_X,    5'd0);
            5'd14:   w = mk_uword(OP_PRE,  12'd9,    CH_I,    5'd16);
            5'd15:   w = mk_uword(OP_SUB,  12'd9,    CH_X,    5'd0);
            5'd16:   w = mk_uword(OP_REP,  12'd5,    CH_V,    5'd0);
            5'd17:   w = mk_uword(OP_PRE,  12'd4,    CH_I,    5'd19);
            5'd18:   w = mk_uword(OP_SUB,  12'd4,    CH_V,    5'd0);
            5'd19:   w = mk_uword(OP_REP,  12'd1,    CH_I,    5'd0);
            default: w = mk_uword(OP_END,  12'd0,    CH_NONE, 5'd0);
        endcase
        return w;
    endfunction

endpackage

### rtl/core/brn_seq.sv
// ----------------------------------------------------------------------------
// brn_seq: microcoded sequencer for Roman numeral letters
// Walks the microcode ROM one step per cycle while i_advance is high, over a
// remainder register, and emits at most one letter per step.
// ----------------------------------------------------------------------------
module brn_seq
    import brn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_advance,
    output logic               o_busy,
    output t_emit              o_emit
);

    logic               r_busy, n_busy;
    logic [PC_W-1:0]    r_pc, n_pc;
    logic [VALUE_W-1:0] r_rem, n_rem;

    t_uword             uw;
    logic               ge;
    logic [VALUE_W-1:0] diff;
    logic               diff_zero;
    t_emit              emit;

    assign uw        = ucode_rom(r_pc);
    assign ge        = (r_rem >= uw.kval);
    assign diff      = r_rem - uw.kval;
    assign diff_zero = (diff == '0);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_rem  = r_rem;
        emit   = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = '0;
            n_rem  = i_value;
        end else if (r_busy && i_advance) begin
            if (r_rem == '0) begin
                n_busy = 1'b0;
            end else begin
                case (uw.op)
                    OP_DROP: begin
                        if (ge) begin
                            n_rem = diff;
                        end
                        n_pc = r_pc + 1'b1;
                    end
                    OP_REP: begin
                        if (ge) begin
                            emit.valid  = 1'b1;
                            emit.symbol = uw.sym;
                            emit.last   = diff_zero;
                            n_rem       = diff;
                            n_busy      = !diff_zero;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    OP_PRE: begin
                        if (ge) begin
                            emit.valid  = 1'b1;
                            emit.symbol = uw.sym;
                            emit.last   = 1'b0;
                            n_pc        = r_pc + 1'b1;
                        end else begin
                            n_pc = uw.tgt;
                        end
                    end
                    OP_SUB: begin
                        emit.valid  = 1'b1;
                        emit.symbol = uw.sym;
                        emit.last   = diff_zero;
                        n_rem       = diff;
                        n_busy      = !diff_zero;
                        n_pc        = r_pc + 1'b1;
                    end
                    default: begin
                        n_busy = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_emit = emit;

    a_emit_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> r_busy && i_advance)
        else $error("letter emitted outside an active conversion");

    a_last_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid && emit.last |=> !r_busy)
        else $error("sequencer still busy after final letter");

    a_pc_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= PC_END)
        else $error("microcode step counter ran past end of program");

endmodule

### rtl/core/binary_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// binary_to_roman_numeral: number to Roman numeral letter stream
// Letters: an accepted number is loaded into the remainder register, and each
//   letter the sequencer emits is registered in the output register.
// Throughput: one microcode step per cycle while the output can take a letter;
//   a new item is taken only once the sequencer is idle again, and a zero
//   value frees it with no letter emitted. Output stalls hold the sequencer.
// Reset: synchronous active-low i_rst_n clears the busy flag, step counter
//   and output valid; remainder and output letter hold no reset.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral
    import brn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [VALUE_W-1:0] i_value,
    // result item channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SYM_W-1:0]   o_symbol,
    output logic               o_last
);

    logic             seq_busy;
    logic             start;
    logic             advance;
    t_emit            emit;

    logic             r_out_valid;
    logic [SYM_W-1:0] r_symbol;
    logic             r_last;

    // Take a new item whenever the sequencer is idle, even while the
    // final letter of the previous numeral still waits in the output register.
    assign start      = i_in_valid && !seq_busy;
    assign o_in_stall = seq_busy;

    // Advance the sequencer only when the output register can take a letter.
    assign advance = !r_out_valid || !i_out_stall;

    brn_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_value   (i_value),
        .i_advance (advance),
        .o_busy    (seq_busy),
        .o_emit    (emit)
    );

    // Output register: load a new letter, or drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold payload while stalled; only a fresh letter overwrites it.
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_symbol <= emit.symbol;
            r_last   <= emit.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit.valid && r_out_valid && i_out_stall))
        else $error("letter overwrote a stalled output item");

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> seq_busy)
        else $error("accepted item did not start the sequencer");

    a_emit_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |=> r_out_valid && r_symbol == $past(emit.symbol))
        else $error("emitted letter not captured in output register");

endmodule

### tb/sv/tb_binary_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// tb_binary_to_roman_numeral: self-checking bench for the Roman numeral block
// Feeds numbers through the input channel in bursts, spells each one as a
// Roman numeral in the bench and checks every letter and its last flag as it
// leaves the result channel, while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_binary_to_roman_numeral;
    import brn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Abort far beyond the slowest legal run: ~160 items, each up to
    // 15 letters behind long stalls and a sender gap.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Covers the sequencer finishing its last item, plus the output register.
    localparam int unsigned DRAIN_CYCLES = 48;
    localparam int unsigned RANDOM_ITEMS = 135;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_letter;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } t_stall_mode;

    // DUT ports; the bench-driven inputs are known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [VALUE_W-1:0] i_value     = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [SYM_W-1:0]   o_symbol;
    logic               o_last;

    // numbers waiting to be sent, and letters waiting to come back
    logic [VALUE_W-1:0] pending_q[$];
    t_letter            numeral_q[$];
    logic [SYM_W-1:0]   spelled_q[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // sender burst shaping
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    bit          hold_item;

    // receiver stall shaping
    t_stall_mode stall_mode  = STALL_NONE;
    int unsigned stall_count = 0;
    logic [7:0]  stall_mask  = '0;
    logic [2:0]  stall_phase = '0;

    t_letter want_letter;

    binary_to_roman_numeral DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Spell one decimal digit with its one/five/ten letters (subtractive form).
    function automatic void spell_digit(input int unsigned d, input logic [SYM_W-1:0] one,
                                        input logic [SYM_W-1:0] five,
                                        input logic [SYM_W-1:0] ten);
        int unsigned rest;
        rest = d;
        if (d == 9) begin
            spelled_q.push_back(one);
            spelled_q.push_back(ten);
        end else if (d == 4) begin
            spelled_q.push_back(one);
            spelled_q.push_back(five);
        end else begin
            if (rest >= 5) begin
                spelled_q.push_back(five);
                rest = rest - 5;
            end
            repeat (rest) spelled_q.push_back(one);
        end
    endfunction

    // Spell the whole numeral and queue its letters; a thousands digit of
    // four prints nothing, and zero queues no letters at all.
    function automatic void predict_numeral(input logic [VALUE_W-1:0] value);
        int unsigned v;
        int unsigned thousands;
        t_letter     l;
        v = value;
        thousands = v / 1000;
        spelled_q.delete();
        if (thousands <= 3) begin
            repeat (thousands) spelled_q.push_back(CH_M);
        end
        spell_digit((v % 1000) / 100, CH_C, CH_D, CH_M);
        spell_digit((v % 100) / 10,   CH_X, CH_L, CH_C);
        spell_digit(v % 10,           CH_I, CH_V, CH_X);
        foreach (spelled_q[k]) begin
            l.symbol = spelled_q[k];
            l.last   = (k == spelled_q.size() - 1);
            numeral_q.push_back(l);
        end
    endfunction

    // Watchdog: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d letters outstanding",
                     cycle_count, numeral_q.size());
            $display("** binary_to_roman_numeral: FAILED **");
            $finish;
        end
    end

    // Driver: advance to the next number only once the current one is taken;
    // hold the payload steady while the block stalls. After half of the bursts,
    // drop valid for a random gap so idle time falls between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = $urandom_range(1, 8);
            gap_left   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_numeral(i_value);
                hold_item = 1'b0;
            end else begin
                hold_item = i_in_valid;
            end
            if (!hold_item) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_value    <= pending_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        // half of the bursts follow straight on
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch stall style every so often, including stretches with
    // no stall at all, heavy back-pressure and a fixed repeating mask.
    always @(posedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode  = t_stall_mode'($urandom_range(0, 3));
            stall_count = $urandom_range(20, 150);
            stall_mask  = 8'($urandom);
        end else begin
            stall_count = stall_count - 1;
        end
        case (stall_mode)
            STALL_NONE:    i_out_stall <= 1'b0;
            STALL_LIGHT:   i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:   i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PATTERN: begin
                i_out_stall <= stall_mask[stall_phase];
                stall_phase = stall_phase + 3'd1;
            end
            default:       i_out_stall <= 1'b0;
        endcase
    end

    // Monitor: check each accepted letter against the oldest one spelled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (numeral_q.size() == 0) begin
                report_mismatch($sformatf("unexpected letter 0x%02h last=%0b",
                                          o_symbol, o_last));
            end else begin
                want_letter = numeral_q.pop_front();
                if (o_symbol !== want_letter.symbol)
                    report_mismatch($sformatf("symbol 0x%02h, want 0x%02h",
                                              o_symbol, want_letter.symbol));
                if (o_last !== want_letter.last)
                    report_mismatch($sformatf("last %0b, want %0b on symbol 0x%02h",
                                              o_last, want_letter.last, want_letter.symbol));
            end
        end
    end

    initial begin
        int unsigned pick;

        // Directed: zero, digit edges (4, 5, 9), longest numeral, upper
        // bound, the dropped thousands digit of four and all-ones input.
        pending_q = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd49,
                      12'd90, 12'd99, 12'd400, 12'd500, 12'd900, 12'd999, 12'd1000,
                      12'd1994, 12'd2444, 12'd3449, 12'd3888, 12'd3999, 12'd4000,
                      12'd4021, 12'd4095, 12'd0, 12'd2048};

        // Random: mostly legal numbers, some with thousands digit four,
        // an occasional zero and raw 12-bit patterns.
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                pending_q.push_back(VALUE_W'($urandom_range(1, 3999)));
            else if (pick < 88)
                pending_q.push_back(VALUE_W'($urandom_range(4000, 4095)));
            else if (pick < 93)
                pending_q.push_back('0);
            else
                pending_q.push_back(VALUE_W'($urandom));
        end

        // Hold reset, then release it.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every number to be taken and every letter to come back.
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || i_in_valid || numeral_q.size() != 0);

        // Let the last number finish in the sequencer; catch stray letters.
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (numeral_q.size() != 0)
            report_mismatch($sformatf("%0d letters never arrived", numeral_q.size()));

        if (error_count == 0) begin
            $display("** binary_to_roman_numeral: PASSED **");
        end else begin
            $display("** binary_to_roman_numeral: FAILED **");
        end
        $finish;
    end

endmodule
